// ----- hw/rtl/cfd_pkg.sv -----
package cfd_pkg;

   // Width of the decoded-byte counter.
   localparam int LEN_BITS = 16;
   // Width of the capacity register and of the reported length.
   localparam int CAP_BITS = 16;
   localparam int OUT_LEN_BITS = 16;
   // Counter and capacity are compared at the wider of the two widths.
   localparam int CMP_BITS = (LEN_BITS > CAP_BITS) ? LEN_BITS : CAP_BITS;

   localparam logic [CAP_BITS-1:0] CAP_RESET = {CAP_BITS{1'b1}};
   localparam logic [CMP_BITS-1:0] LEN_MAX = CMP_BITS'({LEN_BITS{1'b1}});

   // Code byte that opens a full block with no implied zero after it.
   localparam logic [7:0] CODE_FULL_BLOCK = 8'hFF;

   typedef logic [LEN_BITS-1:0] count_type;
   typedef logic [CMP_BITS-1:0] cmp_type;

   typedef enum logic [1:0] {
      MODE_RUN,
      MODE_TRACK,
      MODE_STOP
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0]              out_byte;
      logic                    out_valid;
      logic                    frame_done;
      logic                    err_zero_input;
      logic                    err_input_short;
      logic                    err_overflow;
      logic [OUT_LEN_BITS-1:0] out_length;
   } rsp_type;

   // Input stage contents handed to the decode core.
   typedef struct packed {
      logic    valid;
      req_type item;
   } stage_type;

   // Decode result handed to the output register.
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

// ----- hw/rtl/cfd_in_reg.sv -----
module cfd_in_reg (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  cfd_pkg::req_type req_data,
   input  logic            take,
   output cfd_pkg::stage_type stage
);
   import cfd_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    accept;

   // The register can load whenever it is empty or its item moves on this cycle.
   assign req_ready = !valid_ff || take;
   assign accept = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register; no reset needed.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item = item_ff;

endmodule

// ----- hw/rtl/cfd_core.sv -----
module cfd_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [cfd_pkg::CAP_BITS-1:0] csr_wr_data,
   input  cfd_pkg::stage_type     stage,
   input  logic                   advance,
   output cfd_pkg::result_type    result
);
   import cfd_pkg::*;

   logic [CAP_BITS-1:0] capacity_ff;
   logic [7:0]          block_left_ff, block_left_in;
   logic                zero_pending_ff, zero_pending_in;
   count_type           count_ff, count_in;
   mode_type            mode_ff, mode_in;
   logic                err_zero_ff, err_zero_in;
   logic                err_short_ff, err_short_in;
   logic                err_ovf_ff, err_ovf_in;

   cmp_type    cap_ext;
   cmp_type    cap;
   cmp_type    count_ext;
   cmp_type    count_after_ext;
   count_type  count_after;
   logic       room;
   logic       room_after;
   logic       go;
   logic [7:0] b;
   logic       last;
   logic [7:0] ob;
   logic       valid;

   // Capacity register; the user writes it only while the block is idle, unchecked.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   // The applied limit is the smaller of the register and the counter range.
   assign cap_ext = CMP_BITS'(capacity_ff);
   assign cap = (cap_ext < LEN_MAX) ? cap_ext : LEN_MAX;
   assign count_ext = CMP_BITS'(count_ff);
   assign room = count_ext < cap;

   // A released pending zero bumps the count before the code byte is checked.
   assign count_after = (zero_pending_ff && room) ? count_ff + count_type'(1) : count_ff;
   assign count_after_ext = CMP_BITS'(count_after);
   assign room_after = count_after_ext < cap;

   assign b = stage.item.in_byte;
   assign last = stage.item.in_last;

   // Next state and result for the item in the input register.
   always_comb begin
      block_left_in = block_left_ff;
      zero_pending_in = zero_pending_ff;
      count_in = count_ff;
      mode_in = mode_ff;
      err_zero_in = err_zero_ff;
      err_short_in = err_short_ff;
      err_ovf_in = err_ovf_ff;
      ob = 8'h00;
      valid = 1'b0;
      go = 1'b1;

      case (mode_ff)
         MODE_RUN: begin
            if (block_left_ff == 8'h00) begin
               // Code byte: release the pending zero first.
               if (zero_pending_ff) begin
                  zero_pending_in = 1'b0;
                  if (room) begin
                     valid = 1'b1;
                     count_in = count_after;
                  end else begin
                     err_ovf_in = 1'b1;
                     mode_in = MODE_STOP;
                     go = 1'b0;
                  end
               end
               if (go) begin
                  if (b == 8'h00) begin
                     err_zero_in = 1'b1;
                     mode_in = MODE_STOP;
                  end else begin
                     block_left_in = b - 8'h01;
                     if (!room_after) begin
                        err_ovf_in = 1'b1;
                        mode_in = MODE_TRACK;
                     end else begin
                        zero_pending_in = (b != CODE_FULL_BLOCK);
                     end
                  end
               end
            end else begin
               // Data byte inside a block.
               block_left_in = block_left_ff - 8'h01;
               if (room) begin
                  if (b == 8'h00) begin
                     err_zero_in = 1'b1;
                  end
                  ob = b;
                  valid = 1'b1;
                  count_in = count_ff + count_type'(1);
               end else begin
                  err_ovf_in = 1'b1;
                  zero_pending_in = 1'b0;
                  mode_in = MODE_TRACK;
               end
            end
         end
         MODE_TRACK: begin
            // Count out the rest of the block after an overflow.
            if (block_left_ff != 8'h00) begin
               block_left_in = block_left_ff - 8'h01;
            end else begin
               mode_in = MODE_STOP;
            end
         end
         default: begin
         end
      endcase

      // Frame end: a block left open means the input was short.
      if (last && mode_in != MODE_STOP && block_left_in != 8'h00) begin
         err_short_in = 1'b1;
      end

      result.valid = valid || last;
      result.data.out_byte = ob;
      result.data.out_valid = valid;
      result.data.frame_done = last;
      result.data.err_zero_input = last && err_zero_in;
      result.data.err_input_short = last && err_short_in;
      result.data.err_overflow = last && err_ovf_in;
      result.data.out_length = last ? OUT_LEN_BITS'(count_in) : '0;

      // Per-frame state clears after the frame end is reported.
      if (last) begin
         block_left_in = 8'h00;
         zero_pending_in = 1'b0;
         count_in = '0;
         mode_in = MODE_RUN;
         err_zero_in = 1'b0;
         err_short_in = 1'b0;
         err_ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_left_ff <= 8'h00;
         zero_pending_ff <= 1'b0;
         count_ff <= '0;
         mode_ff <= MODE_RUN;
         err_zero_ff <= 1'b0;
         err_short_ff <= 1'b0;
         err_ovf_ff <= 1'b0;
      end else if (advance) begin
         block_left_ff <= block_left_in;
         zero_pending_ff <= zero_pending_in;
         count_ff <= count_in;
         mode_ff <= mode_in;
         err_zero_ff <= err_zero_in;
         err_short_ff <= err_short_in;
         err_ovf_ff <= err_ovf_in;
      end
   end

endmodule

// ----- hw/rtl/cfd_out_reg.sv -----
module cfd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  cfd_pkg::result_type result,
   output logic                space,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cfd_pkg::rsp_type    rsp_data
);
   import cfd_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   logic    capture;

   // The register takes a new result when empty or being drained this cycle.
   assign space = !valid_ff || rsp_ready;
   assign capture = load && result.valid;

   always_comb begin
      valid_in = valid_ff;
      if (capture) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         data_ff <= result.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

endmodule

// ----- hw/rtl/cobs_frame_decoder.sv -----
// COBS frame decoder.
// The req channel carries one encoded byte per transfer, with in_last set on
// the final byte of a frame. The rsp channel carries one transfer for each
// decoded byte (out_valid set); the frame's last byte also sets frame_done,
// with the error flags and the decoded length, alone if it yields no byte.
// Other bytes yielding nothing, such as plain code bytes, cause no rsp transfer.
// The csr port writes the per-frame output capacity; write it only while no
// frame is in flight.
// A byte's result is held in the input register, then in the output register.
// Throughput: one byte per cycle while rsp_ready is high; the decode step
// between the input register and the output register is combinational.
// When rsp_ready is low the output register holds its result, the input
// register fills, and then req_ready drops until the receiver takes a transfer.
// A synchronous reset empties both registers, clears the frame state and sets
// the capacity to 65535.
module cobs_frame_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cfd_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cfd_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [cfd_pkg::CAP_BITS-1:0]  csr_wr_data
);
   import cfd_pkg::*;

   stage_type  stage;
   result_type result;
   logic       space;
   logic       advance;

   // The item moves through the decode step when the output side has room.
   assign advance = stage.valid && space;

   cfd_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .take      (advance),
      .stage     (stage)
   );

   cfd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stage       (stage),
      .advance     (advance),
      .result      (result)
   );

   cfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
